>>> src/rse_pkg.sv
`default_nettype none
package rse_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 3;

  localparam logic [FuncW-1:0] FuncPush = 3'd0;
  localparam logic [FuncW-1:0] FuncAdd  = 3'd1;
  localparam logic [FuncW-1:0] FuncSub  = 3'd2;
  localparam logic [FuncW-1:0] FuncMul  = 3'd3;
  localparam logic [FuncW-1:0] FuncDiv  = 3'd4;

  localparam logic [StatusW-1:0] StatusOk       = 3'd0;
  localparam logic [StatusW-1:0] StatusFew      = 3'd1;
  localparam logic [StatusW-1:0] StatusDivZero  = 3'd2;
  localparam logic [StatusW-1:0] StatusCount    = 3'd3;
  localparam logic [StatusW-1:0] StatusOverflow = 3'd4;

endpackage
`default_nettype wire

>>> src/rpn_stack_evaluator_unit.sv
`default_nettype none
// Reverse Polish integer evaluator: one token per input word, one result word
// (status in tuser, value in tdata) after the token marked tlast. Divide is
// the slowest token: the 32-step shift-subtract divider sets the worst case.
// The operand stack is a memory with two registered read ports addressed at
// the top two entries, so no clearing pass is needed after reset. Status: 0
// ok, 1 too few operands, 2 divide by zero, 3 final count not one, 4 stack
// overflow; value is zero unless status is 0.
module rpn_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] number
  input  wire logic [2:0]  s_axis_tuser_i,  // [2:0] func
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [31:0] value
  output logic [2:0]       m_axis_tuser_o   // [2:0] status
);

  localparam int unsigned W  = rse_pkg::DataW;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CountFull = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CountOne  = CW'(1);
  localparam logic [CW-1:0] CountTwo  = CW'(2);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDecode = 3'd1;
  localparam logic [2:0] SDiv    = 3'd2;
  localparam logic [2:0] SWrite  = 3'd3;
  localparam logic [2:0] SFinish = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [rse_pkg::StatusW-1:0]  err_q, err_d;
  logic [rse_pkg::FuncW-1:0]    func_q;
  logic [W-1:0]                 num_q;
  logic                         last_q;
  logic [W-1:0]                 res_q, res_d;
  logic [W-1:0]                 bottom_q;
  logic                         out_valid_q, out_valid_d;
  logic [rse_pkg::StatusW-1:0]  out_status_q, out_status_d;
  logic [W-1:0]                 out_value_q, out_value_d;

  logic                         accept;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [W-1:0]                 wdata;
  logic [AW-1:0]                raddr_a, raddr_b;
  logic [W-1:0]                 rhs, lhs;
  logic                         div_start, div_done;
  logic [W-1:0]                 div_quo;
  logic [CW-1:0]                count_m1, count_m2;

  assign count_m1 = count_q - CountOne;
  assign count_m2 = count_q - CountTwo;
  assign raddr_a  = count_m1[AW-1:0];
  assign raddr_b  = count_m2[AW-1:0];

  rse_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rhs),
    .rdata_b_o (lhs)
  );

  rse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lhs),
    .divisor_i  (rhs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready_o = (state_q == SIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    we           = 1'b0;
    waddr        = count_q[AW-1:0];
    wdata        = num_q;
    div_start    = 1'b0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SDecode;
        end
      end
      SDecode: begin
        state_d = SFinish;
        if (err_q == rse_pkg::StatusOk) begin
          case (func_q)
            rse_pkg::FuncPush: begin
              if (count_q == CountFull) begin
                err_d = rse_pkg::StatusOverflow;
              end else begin
                we      = 1'b1;
                count_d = count_q + CountOne;
              end
            end
            rse_pkg::FuncAdd, rse_pkg::FuncSub, rse_pkg::FuncMul, rse_pkg::FuncDiv: begin
              if (count_q < CountTwo) begin
                err_d = rse_pkg::StatusFew;
              end else begin
                case (func_q)
                  rse_pkg::FuncAdd: begin
                    res_d   = lhs + rhs;
                    state_d = SWrite;
                  end
                  rse_pkg::FuncSub: begin
                    res_d   = lhs - rhs;
                    state_d = SWrite;
                  end
                  rse_pkg::FuncMul: begin
                    res_d   = W'(lhs * rhs);
                    state_d = SWrite;
                  end
                  default: begin
                    if (rhs == '0) begin
                      err_d = rse_pkg::StatusDivZero;
                    end else begin
                      div_start = 1'b1;
                      state_d   = SDiv;
                    end
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
      SDiv: begin
        if (div_done) begin
          res_d   = div_quo;
          state_d = SWrite;
        end
      end
      SWrite: begin
        we      = 1'b1;
        waddr   = count_m2[AW-1:0];
        wdata   = res_q;
        count_d = count_m1;
        state_d = SFinish;
      end
      SFinish: begin
        if (!last_q) begin
          state_d = SIdle;
        end else if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (err_q != rse_pkg::StatusOk) begin
            out_status_d = err_q;
          end else if (count_q == CountOne) begin
            out_status_d = rse_pkg::StatusOk;
            out_value_d  = bottom_q;
          end else begin
            out_status_d = rse_pkg::StatusCount;
          end
          count_d = '0;
          err_d   = rse_pkg::StatusOk;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      err_q       <= rse_pkg::StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser_i;
      num_q  <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (we && (waddr == '0)) begin
      bottom_q <= wdata;
    end
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

  a_count_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CountFull
  ) else $error("stack count beyond depth");

  a_result_from_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || m_axis_tready_i) ##1 out_valid_q |->
      $past(state_q == SFinish && last_q)
  ) else $error("result word without a last token");

  a_error_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (err_q != rse_pkg::StatusOk && state_q != SFinish) |=> err_q == $past(err_q)
  ) else $error("pending error changed before end of expression");

endmodule
`default_nettype wire

>>> src/rse_div.sv
`default_nettype none
module rse_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rse_pkg::DataW-1:0]     dividend_i,
  input  wire logic [rse_pkg::DataW-1:0]     divisor_i,
  output logic                               done_o,
  output logic [rse_pkg::DataW-1:0]          quotient_o
);

  localparam int unsigned W    = rse_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    mag_q, mag_d;
  logic [W:0]      rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, mag_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mag_d  = mag_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
      rem_d  = '0;
      quo_d  = dividend_i[W-1] ? W'(0) - dividend_i : dividend_i;
      mag_d  = divisor_i[W-1] ? W'(0) - divisor_i : divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? W'(rem_sh - {1'b0, mag_q}) : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? W'(0) - quo_q : quo_q;

endmodule
`default_nettype wire

>>> src/rse_stack.sv
`default_nettype none
module rse_stack #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0]      waddr_i,
  input  wire logic [rse_pkg::DataW-1:0]           wdata_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0]      raddr_a_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0]      raddr_b_i,
  output logic [rse_pkg::DataW-1:0]                rdata_a_o,
  output logic [rse_pkg::DataW-1:0]                rdata_b_o
);

  logic [rse_pkg::DataW-1:0] mem_q [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

>>> tb/rpn_stack_evaluator_unit_test.sv
module rpn_stack_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth    = 16;
  localparam int unsigned IdleLimit     = 4000;
  localparam int unsigned SettleCycles  = 64;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned PhaseTokens   = 220;

  typedef logic [rse_pkg::FuncW-1:0] func_t;

  localparam func_t                     FuncTopCode = '1;
  localparam logic [rse_pkg::DataW-1:0] MaxInt      = 32'h7FFF_FFFF;
  localparam logic [rse_pkg::DataW-1:0] MinInt      = 32'h8000_0000;
  localparam logic [rse_pkg::DataW-1:0] MinusOne    = '1;

  typedef struct packed {
    logic [rse_pkg::FuncW-1:0] func;
    logic [rse_pkg::DataW-1:0] number;
    logic                      last;
  } token_t;

  typedef struct packed {
    logic [rse_pkg::StatusW-1:0] status;
    logic [rse_pkg::DataW-1:0]   value;
  } result_t;

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [rse_pkg::DataW-1:0]   s_axis_tdata_i  = '0;  // [31:0] number
  logic [rse_pkg::FuncW-1:0]   s_axis_tuser_i  = '0;  // [2:0] func
  logic                        s_axis_tlast_i  = 1'b0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [rse_pkg::DataW-1:0]   m_axis_tdata_o;        // [31:0] value
  logic [rse_pkg::StatusW-1:0] m_axis_tuser_o;        // [2:0] status

  rpn_stack_evaluator_unit #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  token_t                      pending_tokens[$];
  token_t                      expr_buf[$];
  result_t                     expected_results[$];
  logic [rse_pkg::DataW-1:0]   operand_stack[StackDepth];
  int unsigned                 stack_count;
  logic [rse_pkg::StatusW-1:0] pending_error = rse_pkg::StatusOk;
  logic [rse_pkg::FuncW-1:0]   op_codes[4] = '{rse_pkg::FuncAdd, rse_pkg::FuncSub,
                                               rse_pkg::FuncMul, rse_pkg::FuncDiv};

  int src_idle_pct;
  int sink_idle_pct;
  int holdoff_requests;
  int holdoff_served;
  int holdoff_left;
  bit in_taken;
  int error_count;
  int idle_cycles;
  int tokens_sent;
  int tokens_queued;
  int expressions_queued;
  int results_seen;
  int status_tally[8];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [rse_pkg::DataW-1:0] quotient_toward_zero(
    input logic [rse_pkg::DataW-1:0] num,
    input logic [rse_pkg::DataW-1:0] den
  );
    logic [rse_pkg::DataW-1:0] mag_n, mag_d, q;
    mag_n = num[rse_pkg::DataW-1] ? -num : num;
    mag_d = den[rse_pkg::DataW-1] ? -den : den;
    q     = mag_n / mag_d;
    return (num[rse_pkg::DataW-1] ^ den[rse_pkg::DataW-1]) ? -q : q;
  endfunction

  // Advance the stack model by one token; form the expected word on the last one.
  function automatic void eval_token(input token_t t);
    logic [rse_pkg::DataW-1:0] lhs, rhs, res;
    result_t r;
    if (pending_error == rse_pkg::StatusOk) begin
      if (t.func == rse_pkg::FuncPush) begin
        if (stack_count >= StackDepth) begin
          pending_error = rse_pkg::StatusOverflow;
        end else begin
          operand_stack[stack_count] = t.number;
          stack_count++;
        end
      end else if (t.func <= rse_pkg::FuncDiv) begin
        if (stack_count < 2) begin
          pending_error = rse_pkg::StatusFew;
        end else begin
          rhs = operand_stack[stack_count-1];
          lhs = operand_stack[stack_count-2];
          if (t.func == rse_pkg::FuncDiv && rhs == '0) begin
            pending_error = rse_pkg::StatusDivZero;
          end else begin
            case (t.func)
              rse_pkg::FuncAdd: res = lhs + rhs;
              rse_pkg::FuncSub: res = lhs - rhs;
              rse_pkg::FuncMul: res = lhs * rhs;
              default:          res = quotient_toward_zero(lhs, rhs);
            endcase
            stack_count--;
            operand_stack[stack_count-1] = res;
          end
        end
      end
    end
    if (t.last) begin
      r.value = '0;
      if (pending_error != rse_pkg::StatusOk) begin
        r.status = pending_error;
      end else if (stack_count == 1) begin
        r.status = rse_pkg::StatusOk;
        r.value  = operand_stack[0];
      end else begin
        r.status = rse_pkg::StatusCount;
      end
      expected_results.push_back(r);
      status_tally[r.status]++;
      stack_count   = 0;
      pending_error = rse_pkg::StatusOk;
    end
  endfunction

  always @(negedge clk_i) begin : feed
    token_t t;
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (pending_tokens.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        t = pending_tokens.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= t.number;
        s_axis_tuser_i  <= t.func;
        s_axis_tlast_i  <= t.last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left   = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : observe
    token_t  seen;
    result_t want;
    in_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      seen.func   = s_axis_tuser_i;
      seen.number = s_axis_tdata_i;
      seen.last   = s_axis_tlast_i;
      eval_token(seen);
      tokens_sent++;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: status %0d value %0d",
                                  m_axis_tuser_o, $signed(m_axis_tdata_o)));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch($sformatf("status: got %0d, want %0d", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o !== want.value)
          report_mismatch($sformatf("value: got %0d, want %0d",
                                    $signed(m_axis_tdata_o), $signed(want.value)));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no handshake for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_token(input logic [rse_pkg::FuncW-1:0] func,
                           input logic [rse_pkg::DataW-1:0] number);
    token_t t;
    t.func   = func;
    t.number = number;
    t.last   = 1'b0;
    expr_buf.push_back(t);
  endtask

  // Flag the final token of the buffered expression and hand it to the driver.
  task automatic commit_expression();
    token_t t;
    foreach (expr_buf[i]) begin
      t      = expr_buf[i];
      t.last = (i == expr_buf.size() - 1);
      pending_tokens.push_back(t);
      tokens_queued++;
    end
    expr_buf.delete();
    expressions_queued++;
  endtask

  function automatic logic [rse_pkg::DataW-1:0] pick_operand();
    int near_zero;
    near_zero = $urandom_range(16);
    case ($urandom_range(9))
      0, 1, 2, 3: return near_zero - 8;
      4:          return MaxInt;
      5:          return MinInt;
      6:          return MinusOne;
      default:    return $urandom;
    endcase
  endfunction

  task automatic build_wellformed(input int unsigned max_operands);
    int unsigned operands, pushed, depth;
    operands = $urandom_range(max_operands, 1);
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
        add_token(rse_pkg::FuncPush, pick_operand());
        pushed++;
        depth++;
      end else begin
        add_token(op_codes[$urandom_range(3)], $urandom);
        depth--;
      end
      if ($urandom_range(24) == 0)
        add_token(func_t'($urandom_range(FuncTopCode, rse_pkg::FuncDiv + 1)), $urandom);
    end
    commit_expression();
  endtask

  task automatic build_deep();
    int unsigned pushes, ops;
    pushes = $urandom_range(StackDepth + 2, StackDepth - 2);
    ops    = $urandom_range(pushes - 1);
    repeat (pushes) add_token(rse_pkg::FuncPush, pick_operand());
    repeat (ops) add_token(op_codes[$urandom_range(3)], $urandom);
    commit_expression();
  endtask

  task automatic build_broken();
    repeat ($urandom_range(6, 1)) add_token(func_t'($urandom_range(FuncTopCode)), pick_operand());
    commit_expression();
  endtask

  task automatic run_random(input int unsigned tokens_wanted);
    int unsigned start, pick;
    start = tokens_queued;
    while (tokens_queued - start < tokens_wanted) begin
      pick = $urandom_range(99);
      if (pick < 70)
        build_wellformed((pick < 8) ? StackDepth : 6);
      else if (pick < 80)
        build_deep();
      else
        build_broken();
    end
  endtask

  task automatic queue_directed();
    add_token(rse_pkg::FuncPush, MaxInt);
    add_token(rse_pkg::FuncPush, 32'd1);
    add_token(rse_pkg::FuncAdd, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, MinInt);
    add_token(rse_pkg::FuncPush, MinusOne);
    add_token(rse_pkg::FuncDiv, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, -32'sd7);
    add_token(rse_pkg::FuncPush, 32'd2);
    add_token(rse_pkg::FuncDiv, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, 32'd5);
    add_token(rse_pkg::FuncPush, '0);
    add_token(rse_pkg::FuncDiv, $urandom);
    add_token(rse_pkg::FuncPush, 32'd1);
    add_token(rse_pkg::FuncAdd, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncSub, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, 32'd3);
    add_token(rse_pkg::FuncPush, -32'sd4);
    add_token(rse_pkg::FuncMul, $urandom);
    add_token(rse_pkg::FuncPush, 32'd9);
    add_token(rse_pkg::FuncSub, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, 32'd42);
    add_token(FuncTopCode, $urandom);
    commit_expression();
    add_token(rse_pkg::FuncPush, 32'd1);
    add_token(rse_pkg::FuncPush, 32'd2);
    commit_expression();
    add_token(FuncTopCode, $urandom);
    commit_expression();
  endtask

  // Hold until the driver is empty and every expected word has come back.
  task automatic wait_drained();
    while (pending_tokens.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    src_idle_pct  = 36;
    sink_idle_pct = 54;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    queue_directed();
    wait_drained();
    run_random(PhaseTokens);
    wait_drained();

    src_idle_pct  = 54;
    sink_idle_pct = 36;
    run_random(PhaseTokens);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    holdoff_requests++;
    repeat (20) build_wellformed(2);
    run_random(PhaseTokens);
    wait_drained();

    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_results.size()));

    $display("Run covered %0d tokens in %0d expressions; %0d result words checked.",
             tokens_sent, expressions_queued, results_seen);
    $display("Status mix: ok %0d, too few %0d, div by zero %0d, bad count %0d, overflow %0d",
             status_tally[rse_pkg::StatusOk], status_tally[rse_pkg::StatusFew],
             status_tally[rse_pkg::StatusDivZero], status_tally[rse_pkg::StatusCount],
             status_tally[rse_pkg::StatusOverflow]);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
